/* design/edpm_pkg.sv */
// ----------------------------------------------------------------------------
// edpm_pkg: shared types and helpers for the exact drift map
// Widths, item and pass-along records, split multiplier helpers.
// ----------------------------------------------------------------------------
package edpm_pkg;

  localparam int DATA_W        = 48;
  localparam int CFG_W         = 47;
  localparam int HALF_W        = 24;
  localparam int WIDE_W        = 96;
  localparam int SUM_W         = 98;
  localparam int FRAC_BITS_DEF = 32;
  localparam int CFG_IDX_W     = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_BETA0 = 1'b0,
    CFG_DRIFT_LEN = 1'b1
  } cfg_idx_t;

  typedef logic signed [DATA_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t px;
    coord_t y;
    coord_t py;
    coord_t tau;
    coord_t delta;
    coord_t pt;
    coord_t s;
  } item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t tau;
    coord_t s;
    coord_t px;
    coord_t py;
    coord_t pt;
    logic   bad;
  } carry_t;

  typedef struct packed {
    coord_t new_x;
    coord_t new_y;
    coord_t new_tau;
    coord_t new_s;
    logic   invalid;
  } result_t;

  typedef struct packed {
    logic [2*HALF_W-1:0] hh;
    logic [2*HALF_W-1:0] hl;
    logic [2*HALF_W-1:0] lh;
    logic [2*HALF_W-1:0] ll;
  } pp_t;

  // magnitude of a signed value one bit wider than a coordinate
  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W:0] v);
    logic [DATA_W:0] n;
    n = v[DATA_W] ? (~v + 1'b1) : v;
    return n[DATA_W-1:0];
  endfunction

  function automatic pp_t mul_parts(input logic [DATA_W-1:0] a,
                                    input logic [DATA_W-1:0] b);
    pp_t p;
    p.hh = a[DATA_W-1:HALF_W] * b[DATA_W-1:HALF_W];
    p.hl = a[DATA_W-1:HALF_W] * b[HALF_W-1:0];
    p.lh = a[HALF_W-1:0] * b[DATA_W-1:HALF_W];
    p.ll = a[HALF_W-1:0] * b[HALF_W-1:0];
    return p;
  endfunction

  function automatic logic [WIDE_W-1:0] pp_sum(input pp_t p);
    return (WIDE_W'(p.hh) << (2*HALF_W)) + (WIDE_W'(p.hl) << HALF_W) +
           (WIDE_W'(p.lh) << HALF_W) + WIDE_W'(p.ll);
  endfunction

endpackage

/* design/edpm_front.sv */
// ----------------------------------------------------------------------------
// edpm_front: square-root argument
// Forms (1+delta)^2 - px^2 - py^2 exactly over four stages.
// ----------------------------------------------------------------------------
module edpm_front import edpm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              i_vld,
  input  item_t             i_item,
  output logic              o_vld,
  output carry_t            o_carry,
  output logic [WIDE_W-1:0] o_arg
);

  logic [3:0]        vld_r;
  carry_t            c0_r, c1_r, c2_r, c3_r;
  logic [DATA_W-1:0] md_r, mx_r, my_r;
  pp_t               pd_r, px_r, py_r;
  logic [WIDE_W-1:0] sd_r, sx_r, sy_r;
  logic [WIDE_W-1:0] arg_r;

  logic [DATA_W:0]   d1;
  logic [SUM_W-1:0]  arg_nxt;
  carry_t            c0_nxt, c3_nxt;

  always_comb begin
    d1 = {i_item.delta[DATA_W-1], i_item.delta} + ((DATA_W+1)'(1) << FRAC_BITS);
    c0_nxt.x   = i_item.x;
    c0_nxt.y   = i_item.y;
    c0_nxt.tau = i_item.tau;
    c0_nxt.s   = i_item.s;
    c0_nxt.px  = i_item.px;
    c0_nxt.py  = i_item.py;
    c0_nxt.pt  = i_item.pt;
    c0_nxt.bad = 1'b0;
    arg_nxt = {2'b00, sd_r} - {2'b00, sx_r} - {2'b00, sy_r};
    c3_nxt = c2_r;
    c3_nxt.bad = arg_nxt[SUM_W-1] || (arg_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], i_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_r  <= mag(d1);
      mx_r  <= mag({i_item.px[DATA_W-1], i_item.px});
      my_r  <= mag({i_item.py[DATA_W-1], i_item.py});
      c0_r  <= c0_nxt;
      pd_r  <= mul_parts(md_r, md_r);
      px_r  <= mul_parts(mx_r, mx_r);
      py_r  <= mul_parts(my_r, my_r);
      c1_r  <= c0_r;
      sd_r  <= pp_sum(pd_r);
      sx_r  <= pp_sum(px_r);
      sy_r  <= pp_sum(py_r);
      c2_r  <= c1_r;
      arg_r <= arg_nxt[WIDE_W-1:0];
      c3_r  <= c3_nxt;
    end
  end

  assign o_vld   = vld_r[3];
  assign o_carry = c3_r;
  assign o_arg   = arg_r;

endmodule

/* design/edpm_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// edpm_sqrt_cell: one root bit
// Decides root bit BIT from the running remainder and passes on.
// ----------------------------------------------------------------------------
module edpm_sqrt_cell import edpm_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              i_vld,
  input  carry_t            i_carry,
  input  logic [WIDE_W-1:0] i_rem,
  input  logic [DATA_W-1:0] i_root,
  output logic              o_vld,
  output carry_t            o_carry,
  output logic [WIDE_W-1:0] o_rem,
  output logic [DATA_W-1:0] o_root
);

  logic              vld_r;
  carry_t            carry_r;
  logic [WIDE_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] root_r, root_nxt;
  logic [WIDE_W:0]   trial;
  logic              ge;

  always_comb begin
    trial = ((WIDE_W+1)'(i_root) << (BIT+1)) + ((WIDE_W+1)'(1) << (2*BIT));
    ge = ({1'b0, i_rem} >= trial);
    rem_nxt  = ge ? (i_rem - trial[WIDE_W-1:0]) : i_rem;
    root_nxt = ge ? (i_root | (DATA_W'(1) << BIT)) : i_root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry_r <= i_carry;
      rem_r   <= rem_nxt;
      root_r  <= root_nxt;
    end
  end

  assign o_vld   = vld_r;
  assign o_carry = carry_r;
  assign o_rem   = rem_r;
  assign o_root  = root_r;

endmodule

/* design/edpm_div_cell.sv */
// ----------------------------------------------------------------------------
// edpm_div_cell: one quotient bit
// Restoring division step for quotient bit BIT.
// ----------------------------------------------------------------------------
module edpm_div_cell import edpm_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              i_vld,
  input  carry_t            i_carry,
  input  logic [WIDE_W-1:0] i_rem,
  input  logic [DATA_W-1:0] i_quo,
  input  logic [DATA_W-1:0] i_den,
  output logic              o_vld,
  output carry_t            o_carry,
  output logic [WIDE_W-1:0] o_rem,
  output logic [DATA_W-1:0] o_quo,
  output logic [DATA_W-1:0] o_den
);

  logic              vld_r;
  carry_t            carry_r;
  logic [WIDE_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] den_r;
  logic [WIDE_W:0]   trial;
  logic              ge;

  always_comb begin
    trial   = (WIDE_W+1)'(i_den) << BIT;
    ge      = ({1'b0, i_rem} >= trial);
    rem_nxt = ge ? (i_rem - trial[WIDE_W-1:0]) : i_rem;
    quo_nxt = ge ? (i_quo | (DATA_W'(1) << BIT)) : i_quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry_r <= i_carry;
      rem_r   <= rem_nxt;
      quo_r   <= quo_nxt;
      den_r   <= i_den;
    end
  end

  assign o_vld   = vld_r;
  assign o_carry = carry_r;
  assign o_rem   = rem_r;
  assign o_quo   = quo_r;
  assign o_den   = den_r;

endmodule

/* design/edpm_back.sv */
// ----------------------------------------------------------------------------
// edpm_back: coordinate update
// Products with pzi, floor shift, sums and saturation over four stages.
// ----------------------------------------------------------------------------
module edpm_back import edpm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              i_vld,
  input  carry_t            i_carry,
  input  logic [DATA_W-1:0] i_pzi,
  input  logic [CFG_W-1:0]  inv_beta0,
  input  logic [CFG_W-1:0]  drift_len,
  output logic              o_vld,
  output result_t           o_res
);

  localparam logic signed [SUM_W-1:0] SMAX = (SUM_W'(1) << (DATA_W-1)) - 1;
  localparam logic signed [SUM_W-1:0] SMIN = -SMAX - 1;

  function automatic logic signed [WIDE_W:0] apply_sign(input logic [WIDE_W-1:0] m,
                                                       input logic neg);
    logic signed [WIDE_W:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  function automatic coord_t sat(input logic signed [SUM_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v > SMAX) r = SMAX[DATA_W-1:0];
    else if (v < SMIN) r = SMIN[DATA_W-1:0];
    else r = v[DATA_W-1:0];
    return $signed(r);
  endfunction

  logic [3:0]               vld_r;
  carry_t                   c0_r, c1_r, c2_r, c3_r;
  logic [DATA_W-1:0]        mpx_r, mpy_r, mpt_r, pzi_r;
  logic                     spx_r, spy_r, spt_r;
  logic                     npx_r, npy_r, npt_r;
  pp_t                      ppx_r, ppy_r, ppt_r, plb_r;
  logic signed [WIDE_W:0]   prx_r, pry_r, prt_r, prl_r;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r, sum_t_r, sum_s_r;
  logic [DATA_W:0]          ibpt;

  assign ibpt = {2'b00, inv_beta0} + {i_carry.pt[DATA_W-1], i_carry.pt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], i_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mpx_r   <= mag({i_carry.px[DATA_W-1], i_carry.px});
      mpy_r   <= mag({i_carry.py[DATA_W-1], i_carry.py});
      mpt_r   <= mag(ibpt);
      spx_r   <= i_carry.px[DATA_W-1];
      spy_r   <= i_carry.py[DATA_W-1];
      spt_r   <= ibpt[DATA_W];
      pzi_r   <= i_pzi;
      c0_r    <= i_carry;
      ppx_r   <= mul_parts(mpx_r, pzi_r);
      ppy_r   <= mul_parts(mpy_r, pzi_r);
      ppt_r   <= mul_parts(mpt_r, pzi_r);
      plb_r   <= mul_parts({1'b0, drift_len}, {1'b0, inv_beta0});
      npx_r   <= spx_r;
      npy_r   <= spy_r;
      npt_r   <= spt_r;
      c1_r    <= c0_r;
      prx_r   <= apply_sign(pp_sum(ppx_r), npx_r);
      pry_r   <= apply_sign(pp_sum(ppy_r), npy_r);
      prt_r   <= apply_sign(pp_sum(ppt_r), npt_r);
      prl_r   <= apply_sign(pp_sum(plb_r), 1'b0);
      c2_r    <= c1_r;
      sum_x_r <= SUM_W'($signed(c2_r.x)) + SUM_W'(prx_r >>> FRAC_BITS);
      sum_y_r <= SUM_W'($signed(c2_r.y)) + SUM_W'(pry_r >>> FRAC_BITS);
      sum_t_r <= SUM_W'($signed(c2_r.tau)) + SUM_W'(prl_r >>> FRAC_BITS)
                 - SUM_W'(prt_r >>> FRAC_BITS);
      sum_s_r <= SUM_W'($signed(c2_r.s)) + SUM_W'($signed({1'b0, drift_len}));
      c3_r    <= c2_r;
    end
  end

  always_comb begin
    if (c3_r.bad) begin
      o_res.new_x   = c3_r.x;
      o_res.new_y   = c3_r.y;
      o_res.new_tau = c3_r.tau;
      o_res.new_s   = c3_r.s;
    end else begin
      o_res.new_x   = sat(sum_x_r);
      o_res.new_y   = sat(sum_y_r);
      o_res.new_tau = sat(sum_t_r);
      o_res.new_s   = sat(sum_s_r);
    end
    o_res.invalid = c3_r.bad;
  end

  assign o_vld = vld_r[3];

endmodule

/* design/exact_drift_particle_map.sv */
// ----------------------------------------------------------------------------
// exact_drift_particle_map: exact drift map, one particle per item
// Argument stages, root cells, divider cells, then the coordinate update.
//
//   port group   dir   contents
//   in_*         in    particle item, 8 coordinates
//   out_*        out   updated coordinates, invalid in tuser
//   cfg_*        in    register writes
//
// one item per cycle while the output is not held; the chain has 4 argument stages,
// 48 root cells, 48 divider cells, 4 update stages and an output register
// the whole chain moves together and holds while the output item waits
// one item is still taken into the input skid register during a hold
// synchronous active-low reset clears valids and loads register defaults
// ----------------------------------------------------------------------------
module exact_drift_particle_map import edpm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pos_x, mom_x, pos_y, mom_y, time_lag, momentum_dev, energy_dev, path_pos
  input  logic [8*DATA_W-1:0]    in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // new_x, new_y, new_tau, new_s
  output logic [4*DATA_W-1:0]    out_tdata,
  // invalid
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  logic [CFG_W-1:0] inv_beta0_r, drift_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_beta0_r <= CFG_W'(1) << FRAC_BITS;
      drift_len_r <= CFG_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INV_BETA0: inv_beta0_r <= cfg_wdata;
        CFG_DRIFT_LEN: drift_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic    en;
  logic    in_acc;
  item_t   in_item, skid_r, front_item;
  logic    skid_vld_r, skid_vld_nxt;
  logic    front_vld;
  result_t out_res_r, back_res;
  logic    out_vld_r;
  logic    back_vld;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = !skid_vld_r;
  assign in_acc    = in_tvalid && in_tready;

  assign in_item.x     = in_tdata[0*DATA_W +: DATA_W];
  assign in_item.px    = in_tdata[1*DATA_W +: DATA_W];
  assign in_item.y     = in_tdata[2*DATA_W +: DATA_W];
  assign in_item.py    = in_tdata[3*DATA_W +: DATA_W];
  assign in_item.tau   = in_tdata[4*DATA_W +: DATA_W];
  assign in_item.delta = in_tdata[5*DATA_W +: DATA_W];
  assign in_item.pt    = in_tdata[6*DATA_W +: DATA_W];
  assign in_item.s     = in_tdata[7*DATA_W +: DATA_W];

  assign front_vld    = skid_vld_r || in_acc;
  assign front_item   = skid_vld_r ? skid_r : in_item;
  assign skid_vld_nxt = en ? 1'b0 : (skid_vld_r || in_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_acc) begin
      skid_r <= in_item;
    end
  end

  logic              sq_vld   [0:DATA_W];
  carry_t            sq_carry [0:DATA_W];
  logic [WIDE_W-1:0] sq_rem   [0:DATA_W];
  logic [DATA_W-1:0] sq_root  [0:DATA_W];

  edpm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_vld   (front_vld),
    .i_item  (front_item),
    .o_vld   (sq_vld[0]),
    .o_carry (sq_carry[0]),
    .o_arg   (sq_rem[0])
  );

  assign sq_root[0] = '0;

  logic              dv_vld   [0:DATA_W];
  carry_t            dv_carry [0:DATA_W];
  logic [WIDE_W-1:0] dv_rem   [0:DATA_W];
  logic [DATA_W-1:0] dv_quo   [0:DATA_W];
  logic [DATA_W-1:0] dv_den   [0:DATA_W];

  for (genvar g = 0; g < DATA_W; g++) begin : g_sqrt
    edpm_sqrt_cell #(.BIT(DATA_W-1-g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .i_vld   (sq_vld[g]),
      .i_carry (sq_carry[g]),
      .i_rem   (sq_rem[g]),
      .i_root  (sq_root[g]),
      .o_vld   (sq_vld[g+1]),
      .o_carry (sq_carry[g+1]),
      .o_rem   (sq_rem[g+1]),
      .o_root  (sq_root[g+1])
    );
  end

  assign dv_vld[0]   = sq_vld[DATA_W];
  assign dv_carry[0] = sq_carry[DATA_W];
  assign dv_rem[0]   = WIDE_W'(drift_len_r) << FRAC_BITS;
  assign dv_quo[0]   = '0;
  assign dv_den[0]   = sq_root[DATA_W];

  for (genvar g = 0; g < DATA_W; g++) begin : g_div
    edpm_div_cell #(.BIT(DATA_W-1-g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .i_vld   (dv_vld[g]),
      .i_carry (dv_carry[g]),
      .i_rem   (dv_rem[g]),
      .i_quo   (dv_quo[g]),
      .i_den   (dv_den[g]),
      .o_vld   (dv_vld[g+1]),
      .o_carry (dv_carry[g+1]),
      .o_rem   (dv_rem[g+1]),
      .o_quo   (dv_quo[g+1]),
      .o_den   (dv_den[g+1])
    );
  end

  logic [DATA_W-1:0] pzi;

  // clamp pzi to the largest positive coordinate
  assign pzi = dv_quo[DATA_W][DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : dv_quo[DATA_W];

  edpm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .i_vld     (dv_vld[DATA_W]),
    .i_carry   (dv_carry[DATA_W]),
    .i_pzi     (pzi),
    .inv_beta0 (inv_beta0_r),
    .drift_len (drift_len_r),
    .o_vld     (back_vld),
    .o_res     (back_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= back_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= back_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_res_r.new_s, out_res_r.new_tau, out_res_r.new_y, out_res_r.new_x};
  assign out_tuser  = out_res_r.invalid;

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: regression bench for the exact drift particle map
// Drives particle items through the stream input and checks every result against
// an in-bench fixed point predictor of the exact drift, or pass-through rows
// against their table. It runs a short directed table, then random particles
// over several register settings and idle patterns, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import edpm_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam coord_t ONE = 48'sh0001_0000_0000;
  localparam coord_t CMAX = 48'sh7FFF_FFFF_FFFF;
  localparam coord_t CMIN = 48'sh8000_0000_0000;
  localparam logic [CFG_W-1:0] REG_MAX = {CFG_W{1'b1}};
  localparam logic [CFG_W-1:0] REG_ONE = 47'h1_0000_0000;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [8*DATA_W-1:0]  in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [4*DATA_W-1:0]  out_tdata;
  logic                 out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic [CFG_W-1:0] ib_reg = REG_ONE;
  logic [CFG_W-1:0] len_reg = REG_ONE;
  result_t pending_tracks[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cnt = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_invalid = 0;
  int n_settings = 1;

  exact_drift_particle_map u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic coord_t sat48(input logic signed [159:0] v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic result_t drift_predict(input item_t p);
    logic signed [159:0] d1, arg, pz, ln, ib;
    logic [127:0] root, cand, numer, quot;
    result_t r;
    d1 = 160'(p.delta);
    d1 = d1 + ONE;
    arg = d1 * d1 - p.px * p.px - p.py * p.py;
    if (arg <= 0) begin
      r = '{new_x: p.x, new_y: p.y, new_tau: p.tau, new_s: p.s, invalid: 1'b1};
      return r;
    end
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= arg[127:0]) root = cand;
    end
    numer = 128'(len_reg) << FB;
    quot = numer / root;
    if (quot > 128'(CMAX)) quot = 128'(CMAX);
    pz = 160'(quot);
    ln = 160'(len_reg);
    ib = 160'(ib_reg);
    r.new_x = sat48(p.x + ((p.px * pz) >>> FB));
    r.new_y = sat48(p.y + ((p.py * pz) >>> FB));
    r.new_tau = sat48(p.tau + ((ln * ib) >>> FB) - (((ib + p.pt) * pz) >>> FB));
    r.new_s = sat48(p.s + ln);
    r.invalid = 1'b0;
    return r;
  endfunction

  function automatic item_t mk(input coord_t x, px, y, py, tau, delta, pt, s);
    item_t it;
    it.x = x; it.px = px; it.y = y; it.py = py;
    it.tau = tau; it.delta = delta; it.pt = pt; it.s = s;
    return it;
  endfunction

  function automatic coord_t rnd_full();
    return coord_t'({$urandom(), $urandom()});
  endfunction

  // signed value in [-2^bits, 2^bits)
  function automatic coord_t rnd_small(input int bits);
    return rnd_full() >>> (DATA_W - 1 - bits);
  endfunction

  function automatic item_t rnd_particle();
    int k;
    coord_t d;
    k = $urandom_range(99);
    if (k < 70)
      return mk(rnd_small(36), rnd_small(29), rnd_small(36), rnd_small(29),
                rnd_small(36), rnd_small(28), rnd_small(28), rnd_small(40));
    if (k < 82) begin
      d = rnd_small(30);
      return mk(rnd_small(40), ONE + d - rnd_small(14), rnd_small(40), rnd_small(12),
                rnd_small(40), d, rnd_small(30), rnd_small(46));
    end
    if (k < 92)
      return mk(rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                rnd_full(), rnd_full(), rnd_full(), rnd_full());
    return mk(rnd_full(), rnd_small(31), rnd_full(), rnd_small(31),
              rnd_full(), rnd_small(31), rnd_full(), rnd_full());
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push(input item_t it, input bit typed, input result_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {it.s, it.pt, it.delta, it.tau, it.py, it.y, it.px, it.x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_tracks.push_back(typed ? res : drift_predict(it));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_tracks.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] ib, input logic [CFG_W-1:0] ln);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INV_BETA0;
    cfg_wdata <= ib;
    ib_reg = ib;
    @(negedge clk);
    cfg_index <= CFG_DRIFT_LEN;
    cfg_wdata <= ln;
    len_reg = ln;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(input int count, input int mode, input bit hold);
    result_t none;
    none = '0;
    idle_pct = (mode == 1) ? 72 : (mode == 3) ? 29 : 0;
    stall_pct = (mode == 2) ? 72 : (mode == 3) ? 29 : 0;
    for (int i = 0; i < count; i++) begin
      if (hold && i == 20) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        hold_cnt = 400;
        @(negedge clk);
      end
      push(rnd_particle(), 1'b0, none);
    end
  endtask

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.new_x = out_tdata[DATA_W-1:0];
      got.new_y = out_tdata[2*DATA_W-1:DATA_W];
      got.new_tau = out_tdata[3*DATA_W-1:2*DATA_W];
      got.new_s = out_tdata[4*DATA_W-1:3*DATA_W];
      got.invalid = out_tuser;
      n_recv++;
      if (got.invalid) n_invalid++;
      if (pending_tracks.size() == 0) begin
        $display("%0t: unexpected item %h", $time, got);
        n_errors++;
      end else begin
        want = pending_tracks.pop_front();
        if (got.new_x !== want.new_x) begin
          $display("%0t: new_x exp %h act %h", $time, want.new_x, got.new_x);
          n_errors++;
        end
        if (got.new_y !== want.new_y) begin
          $display("%0t: new_y exp %h act %h", $time, want.new_y, got.new_y);
          n_errors++;
        end
        if (got.new_tau !== want.new_tau) begin
          $display("%0t: new_tau exp %h act %h", $time, want.new_tau, got.new_tau);
          n_errors++;
        end
        if (got.new_s !== want.new_s) begin
          $display("%0t: new_s exp %h act %h", $time, want.new_s, got.new_s);
          n_errors++;
        end
        if (got.invalid !== want.invalid) begin
          $display("%0t: invalid exp %b act %b", $time, want.invalid, got.invalid);
          n_errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    coord_t z;
    z = '0;
    rw.typed = 1'b0; rw.res = '0;
    // zero particle
    rw.it = mk(z, z, z, z, z, z, z, z); rows.push_back(rw);
    // small typical particle
    rw.it = mk(48'sh2_0000_0000, 48'sh0_0100_0000, -48'sh1_0000_0000, -48'sh0_0080_0000,
               48'sh0_1000_0000, 48'sh0_0200_0000, -48'sh0_0100_0000, 48'sh10_0000_0000);
    rows.push_back(rw);
    // tiny root argument, pzi saturates
    rw.it = mk(z, ONE - 1, z, z, z, z, z, z); rows.push_back(rw);
    rw.it = mk(z, z, z, -(ONE - 1), z, z, z, z); rows.push_back(rw);
    // coordinate overflow both ways
    rw.it = mk(CMAX, 48'sh0_8000_0000, CMAX, 48'sh0_8000_0000, CMIN, z, CMAX, CMAX);
    rows.push_back(rw);
    rw.it = mk(CMIN, -48'sh0_8000_0000, CMIN, -48'sh0_8000_0000, CMAX, z, CMIN, CMIN);
    rows.push_back(rw);
    // most negative and most positive delta, still valid
    rw.it = mk(z, z, z, z, z, CMIN, z, z); rows.push_back(rw);
    rw.it = mk(z, 48'sh0_4000_0000, z, z, z, CMAX, z, z); rows.push_back(rw);
    // non-positive argument passes through
    rw.typed = 1'b1;
    rw.it = mk(48'sh5, z, 48'sh6, z, 48'sh7, -ONE, z, 48'sh8);
    rw.res = '{new_x: 48'sh5, new_y: 48'sh6, new_tau: 48'sh7, new_s: 48'sh8, invalid: 1'b1};
    rows.push_back(rw);
    rw.it = mk(CMAX, ONE, CMIN, z, CMAX, z, CMIN, CMIN);
    rw.res = '{new_x: CMAX, new_y: CMIN, new_tau: CMAX, new_s: CMIN, invalid: 1'b1};
    rows.push_back(rw);
    rw.it = mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    rw.res = '{new_x: CMAX, new_y: CMAX, new_tau: CMAX, new_s: CMAX, invalid: 1'b1};
    rows.push_back(rw);
    rw.it = mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    rw.res = '{new_x: CMIN, new_y: CMIN, new_tau: CMIN, new_s: CMIN, invalid: 1'b1};
    rows.push_back(rw);
    rw.it = mk(-48'sh1, z, z, ONE, z, z, z, 48'sh1);
    rw.res = '{new_x: -48'sh1, new_y: z, new_tau: z, new_s: 48'sh1, invalid: 1'b1};
    rows.push_back(rw);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) push(rows[i].it, rows[i].typed, rows[i].res);
    run_random(40, 0, 1'b0);
    drain();

    set_regs(REG_MAX, REG_MAX);
    for (int i = 0; i < 4; i++) push(rows[i].it, 1'b0, rows[i].res);
    run_random(200, 1, 1'b0);
    drain();

    set_regs(REG_ONE, '0);
    run_random(200, 2, 1'b0);
    drain();

    // inverse beta below one is taken as is
    set_regs(47'h0_8000_0000, CFG_W'($urandom_range(32'hFFFF_FFFF)));
    run_random(200, 3, 1'b1);
    drain();

    set_regs(CFG_W'({$urandom(), $urandom()} | REG_ONE),
             CFG_W'({$urandom_range(255), $urandom()}));
    run_random(250, $urandom_range(3), 1'b0);
    drain();

    $display("%0d particles sent, %0d results checked, %0d flagged invalid",
             n_sent, n_recv, n_invalid);
    $display("%0d register settings, all idle patterns and a long output hold-off",
             n_settings);
    if (n_errors == 0 && pending_tracks.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/edpm_pkg.sv
design/edpm_front.sv
design/edpm_sqrt_cell.sv
design/edpm_div_cell.sv
design/edpm_back.sv
design/exact_drift_particle_map.sv
tb/sv/tb_top.sv
